[rtl/jss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package jss_pkg;

  // Set geometry and number format
  localparam int SET_DEPTH = 64;
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int UNI_W     = CNT_W + 1;
  localparam int NUM_W     = CNT_W + FRAC_BITS;

  // Beat field widths
  localparam int REQ_W     = 2;
  localparam int SIM_W     = 23;
  localparam int INTER_W   = 7;
  localparam int UNION_W   = 8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_APPEND_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH   = 2'd2;

endpackage
`default_nettype wire

[rtl/jss_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface jss_req_if;
  import jss_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [ELEM_W-1:0]  element;

  modport source (output valid, output req_type, output element, input ready);
  modport sink   (input valid, input req_type, input element, output ready);
endinterface

interface jss_res_if;
  import jss_pkg::*;

  logic               valid;
  logic               ready;
  logic [SIM_W-1:0]   similarity;
  logic [INTER_W-1:0] intersection_count;
  logic [UNION_W-1:0] union_count;
  logic               overflowed;

  modport source (output valid, output similarity, output intersection_count,
                  output union_count, output overflowed, input ready);
  modport sink   (input valid, input similarity, input intersection_count,
                  input union_count, input overflowed, output ready);
endinterface
`default_nettype wire

[rtl/jss_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module jss_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/jss_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module jss_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [jss_pkg::NUM_W-1:0] num,
  input  wire logic [jss_pkg::UNI_W-1:0] den,
  output logic                           done,
  output logic      [jss_pkg::NUM_W-1:0] quo
);
  import jss_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [UNI_W-1:0]  rem;
  logic [UNI_W-1:0]  div_den;
  logic [UNI_W:0]    trial;
  logic              fits;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      // Pulse done after the last step
      done <= !start && busy && (step == STEP_W'(NUM_W - 1));
      if (start) begin
        busy    <= 1'b1;
        step    <= '0;
        rem     <= '0;
        quo     <= num;
        div_den <= den;
      end else if (busy) begin
        rem  <= fits ? UNI_W'(trial - {1'b0, div_den}) : trial[UNI_W-1:0];
        quo  <= {quo[NUM_W-2:0], fits};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/jaccard_set_similarity.sv]
`timescale 1ns / 1ps
`default_nettype none
// Jaccard similarity of two element sets. Append beats (set A or set B) are
// taken one per cycle and written straight into the set memories; an append
// to a full set is dropped and raises the overflow flag. A finish beat scans
// every A entry against the B entries, one compare per cycle from the B
// memory port, stopping at the first match, with a fetch state for each A
// entry. A bit-serial divider then forms intersection / union with 16
// fraction bits. The result beat waits in an output register; both sets and
// the flag clear when it is loaded. Two empty sets give 1.0. No new request
// is taken from finish until the result is loaded.
module jaccard_set_similarity (
  input  wire logic clk,
  input  wire logic rst,
  jss_req_if.sink   req,
  jss_res_if.source res
);
  import jss_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDA   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_DIVW  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count_a;
  logic [CNT_W-1:0]  count_b;
  logic              overflow_flag;
  logic [ADDR_W-1:0] idx_a;
  logic [ADDR_W-1:0] idx_b;
  logic [CNT_W-1:0]  hits;
  logic [UNI_W-1:0]  uni;
  logic [SIM_W-1:0]  sim;

  logic               res_valid;
  logic [SIM_W-1:0]   res_sim;
  logic [INTER_W-1:0] res_inter;
  logic [UNION_W-1:0] res_union;
  logic               res_ovf;

  logic              accept;
  logic              full_a;
  logic              full_b;
  logic              we_a;
  logic              we_b;
  logic              re_a;
  logic              re_b;
  logic [ADDR_W-1:0] raddr_b;
  logic [ELEM_W-1:0] rdata_a;
  logic [ELEM_W-1:0] rdata_b;
  logic              hit;
  logic              last_a;
  logic              last_b;
  logic              load_res;
  logic [UNI_W-1:0]  uni_next;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;

  // Request side
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full_a    = (count_a == CNT_W'(SET_DEPTH));
  assign full_b    = (count_b == CNT_W'(SET_DEPTH));
  assign we_a      = accept && (req.req_type == REQ_APPEND_A) && !full_a;
  assign we_b      = accept && (req.req_type == REQ_APPEND_B) && !full_b;

  // Scan reads: fetch A entry, then stream B entries one ahead of the compare
  assign re_a    = (state == S_RDA);
  assign re_b    = (state == S_RDA) || (state == S_SCAN);
  assign raddr_b = (state == S_RDA) ? '0 : ADDR_W'(idx_b + ADDR_W'(1));
  assign hit     = (rdata_a == rdata_b);
  assign last_a  = ((CNT_W'(idx_a) + CNT_W'(1)) == count_a);
  assign last_b  = ((CNT_W'(idx_b) + CNT_W'(1)) == count_b);

  jss_ram #(.DEPTH(SET_DEPTH), .WIDTH(ELEM_W), .AW(ADDR_W)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[ADDR_W-1:0]),
    .wdata (req.element),
    .re    (re_a),
    .raddr (idx_a),
    .rdata (rdata_a)
  );

  jss_ram #(.DEPTH(SET_DEPTH), .WIDTH(ELEM_W), .AW(ADDR_W)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[ADDR_W-1:0]),
    .wdata (req.element),
    .re    (re_b),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Union and divide
  assign uni_next  = UNI_W'(count_a) + UNI_W'(count_b) - UNI_W'(hits);
  assign div_start = (state == S_DIVGO);

  jss_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({hits, {FRAC_BITS{1'b0}}}),
    .den   (uni_next),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign load_res = (state == S_OUT) && (!res_valid || res.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      overflow_flag <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (res_valid && res.ready && !load_res) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.req_type)
              REQ_APPEND_A: begin
                if (full_a) overflow_flag <= 1'b1;
                else        count_a <= count_a + CNT_W'(1);
              end
              REQ_APPEND_B: begin
                if (full_b) overflow_flag <= 1'b1;
                else        count_b <= count_b + CNT_W'(1);
              end
              REQ_FINISH: begin
                hits  <= '0;
                idx_a <= '0;
                if (count_a == '0 && count_b == '0) begin
                  sim   <= SIM_W'(1) << FRAC_BITS;
                  uni   <= '0;
                  state <= S_OUT;
                end else if (count_a == '0 || count_b == '0) begin
                  state <= S_DIVGO;
                end else begin
                  state <= S_RDA;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RDA: begin
          idx_b <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (hit || last_b) begin
            hits <= hits + CNT_W'(hit);
            if (last_a) begin
              state <= S_DIVGO;
            end else begin
              idx_a <= idx_a + ADDR_W'(1);
              state <= S_RDA;
            end
          end else begin
            idx_b <= idx_b + ADDR_W'(1);
          end
        end
        S_DIVGO: begin
          uni   <= uni_next;
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            sim   <= SIM_W'(div_quo);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_res) begin
            res_valid     <= 1'b1;
            res_sim       <= sim;
            res_inter     <= INTER_W'(hits);
            res_union     <= UNION_W'(uni);
            res_ovf       <= overflow_flag;
            count_a       <= '0;
            count_b       <= '0;
            overflow_flag <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result beat
  assign res.valid              = res_valid;
  assign res.similarity         = res_sim;
  assign res.intersection_count = res_inter;
  assign res.union_count        = res_union;
  assign res.overflowed         = res_ovf;

  // Set counts never pass the memory depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CNT_W'(SET_DEPTH)) && (count_b <= CNT_W'(SET_DEPTH)))
    else $error("set count exceeds depth");

  // Match count never passes the number of A entries
  a_hits_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (hits <= count_a))
    else $error("intersection exceeds set A size");

  // Loading a result empties both sets
  a_clear_on_load: assert property (@(posedge clk) disable iff (rst)
    load_res |=> (count_a == '0) && (count_b == '0) && !overflow_flag && res_valid)
    else $error("sets not cleared after result load");

  // Scan stays inside the loaded entries
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CNT_W'(idx_a) < count_a) && (CNT_W'(idx_b) < count_b))
    else $error("scan index out of range");

  // Divider finishes only while it is awaited
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVW))
    else $error("divider done outside wait state");

endmodule
`default_nettype wire
